// ===== hw/rtl/cgsl_pkg.sv =====
// shared types and constants for the gradient stop lookup block
`default_nettype none
package cgsl_pkg;
    localparam int MaxStops = 16;
    localparam int IdxW = $clog2(MaxStops);
    localparam int CntW = $clog2(MaxStops + 1);
    localparam int FracBits = 16;
    localparam int PosW = 24;
    localparam int SPosW = FracBits + 1;
    localparam int ColW = 64;
    localparam int AmtW = 16;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        EXT_PAD = 2'd0,
        EXT_REPEAT = 2'd1,
        EXT_REFLECT = 2'd2
    } extend_t;

    localparam logic [1:0] REG_EXTEND = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_LK_FIRST,
        S_LK_LAST,
        S_LK_SCAN,
        S_LK_PAIR,
        S_LK_DIV,
        S_LK_MUL,
        S_OUT
    } state_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic [SPosW-1:0] num;
        logic [SPosW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [AmtW-1:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cgsl_stop_mem.sv =====
// stop table memory, position and color per entry, registered read port
`default_nettype none
module cgsl_stop_mem (
    input wire logic aclk,
    input wire logic we,
    input wire logic [cgsl_pkg::IdxW-1:0] waddr,
    input wire logic [cgsl_pkg::SPosW-1:0] wpos,
    input wire logic [cgsl_pkg::ColW-1:0] wcol,
    input wire logic [cgsl_pkg::IdxW-1:0] raddr,
    output logic [cgsl_pkg::SPosW-1:0] rpos,
    output logic [cgsl_pkg::ColW-1:0] rcol
);
    logic [cgsl_pkg::SPosW-1:0] pos_mem [cgsl_pkg::MaxStops];
    logic [cgsl_pkg::ColW-1:0] col_mem [cgsl_pkg::MaxStops];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            pos_mem[waddr] <= wpos;
            col_mem[waddr] <= wcol;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rpos <= pos_mem[raddr];
        rcol <= col_mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/cgsl_divider.sv =====
// restoring divider for the Q16 interpolation fraction, one quotient bit a cycle
`default_nettype none
module cgsl_divider (
    input wire logic aclk,
    input wire logic aresetn,
    input wire cgsl_pkg::div_req_t req,
    output cgsl_pkg::div_rsp_t rsp
);
    localparam int RemW = cgsl_pkg::SPosW + 1;
    localparam int StepW = $clog2(cgsl_pkg::AmtW + 1);

    logic busy_reg, busy_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [RemW-1:0] rem_reg, rem_next;
    logic [cgsl_pkg::SPosW-1:0] den_reg, den_next;
    logic [cgsl_pkg::AmtW-1:0] quo_reg, quo_next;
    logic done_reg, done_next;
    logic [RemW-1:0] trial;

    // one shift-subtract step per cycle; num < den so quotient fits 16 bits
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        done_next = 1'b0;
        trial = {rem_reg[RemW-2:0], 1'b0};
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next = {1'b0, req.num};
            den_next = req.den;
            quo_next = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[cgsl_pkg::AmtW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[cgsl_pkg::AmtW-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(cgsl_pkg::AmtW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;

    // a result only follows an active division
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("divider done without work");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !req.start |=> busy_reg || done_reg)
        else $error("divider dropped work");
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg < StepW'(cgsl_pkg::AmtW)) else $error("divider overran");
endmodule
`default_nettype wire

// ===== hw/rtl/cgsl_ctrl.sv =====
// sequencer: insertion shift, lookup search, interpolation and result register
`default_nettype none
module cgsl_ctrl (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic [1:0] extend_mode,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [1:0] in_opcode,
    input wire logic [cgsl_pkg::PosW-1:0] in_pos,
    input wire logic [cgsl_pkg::ColW-1:0] in_col,
    output logic out_valid,
    input wire logic out_ready,
    output logic [1:0] out_status,
    output logic [cgsl_pkg::ColW-1:0] out_col,
    output logic mem_we,
    output logic [cgsl_pkg::IdxW-1:0] mem_waddr,
    output logic [cgsl_pkg::SPosW-1:0] mem_wpos,
    output logic [cgsl_pkg::ColW-1:0] mem_wcol,
    output logic [cgsl_pkg::IdxW-1:0] mem_raddr,
    input wire logic [cgsl_pkg::SPosW-1:0] mem_rpos,
    input wire logic [cgsl_pkg::ColW-1:0] mem_rcol,
    output cgsl_pkg::div_req_t div_req,
    input wire cgsl_pkg::div_rsp_t div_rsp
);
    localparam int IW = cgsl_pkg::IdxW;
    localparam int CW = cgsl_pkg::CntW;
    localparam int PW = cgsl_pkg::SPosW;
    localparam logic [PW-1:0] PosOne = PW'(1) << cgsl_pkg::FracBits;

    cgsl_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [cgsl_pkg::ColW-1:0] col_reg, col_next;
    logic [PW-1:0] p1_reg, p1_next;
    logic [cgsl_pkg::ColW-1:0] c1_reg, c1_next;
    logic [PW-1:0] p2_reg, p2_next;
    logic [cgsl_pkg::ColW-1:0] c2_reg, c2_next;
    logic [cgsl_pkg::AmtW-1:0] amt_reg, amt_next;
    logic [1:0] ch_reg, ch_next;
    logic ovalid_reg, ovalid_next;
    logic [1:0] ostat_reg, ostat_next;
    logic [cgsl_pkg::ColW-1:0] ocol_reg, ocol_next;
    logic lookup_empty_reg, lookup_empty_next;
    logic div_run_reg, div_run_next;
    logic accept;
    logic out_free;
    logic pos_neg;
    logic [PW-1:0] folded;
    logic [cgsl_pkg::FracBits-1:0] frac;
    logic [33:0] gray_prod;
    logic [15:0] ca, cb;
    logic [16:0] inv_amt;
    logic [32:0] blend_sum;

    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == cgsl_pkg::S_IDLE) && out_free;
    assign accept = in_valid && in_ready;
    assign pos_neg = in_pos[cgsl_pkg::PosW-1];
    assign frac = in_pos[cgsl_pkg::FracBits-1:0];

    // fold query position into 0..1
    always_comb begin
        case (extend_mode)
            cgsl_pkg::EXT_REPEAT: folded = {1'b0, frac};
            cgsl_pkg::EXT_REFLECT:
                folded = in_pos[cgsl_pkg::FracBits] ? PosOne - {1'b0, frac} : {1'b0, frac};
            default: begin
                if (pos_neg) folded = '0;
                else if (in_pos > cgsl_pkg::PosW'(PosOne)) folded = PosOne;
                else folded = in_pos[PW-1:0];
            end
        endcase
    end

    // empty-table gray ramp and one channel of the blend
    assign gray_prod = 34'(pos_reg) * 34'd65535;
    assign ca = c1_reg[16*ch_reg +: 16];
    assign cb = c2_reg[16*ch_reg +: 16];
    assign inv_amt = 17'd65536 - {1'b0, amt_reg};
    assign blend_sum = 33'(ca) * 33'(inv_amt) + 33'(cb) * 33'(amt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cgsl_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_opcode)
                        cgsl_pkg::OP_ADD: begin
                            if (pos_neg || in_pos > cgsl_pkg::PosW'(PosOne)
                                || count_reg >= CW'(cgsl_pkg::MaxStops))
                                state_next = cgsl_pkg::S_OUT;
                            else if (count_reg == '0)
                                state_next = cgsl_pkg::S_ADD_WR;
                            else
                                state_next = cgsl_pkg::S_ADD_RD;
                        end
                        cgsl_pkg::OP_LOOKUP:
                            state_next = (count_reg == '0) ? cgsl_pkg::S_OUT
                                                           : cgsl_pkg::S_LK_FIRST;
                        default: state_next = cgsl_pkg::S_OUT;
                    endcase
                end
            end
            cgsl_pkg::S_ADD_RD: begin
                if (pos_reg >= mem_rpos || idx_reg == CW'(1))
                    state_next = cgsl_pkg::S_ADD_WR;
            end
            cgsl_pkg::S_ADD_WR: state_next = cgsl_pkg::S_OUT;
            cgsl_pkg::S_LK_FIRST: begin
                if (count_reg == CW'(1) || pos_reg <= mem_rpos)
                    state_next = cgsl_pkg::S_OUT;
                else
                    state_next = cgsl_pkg::S_LK_LAST;
            end
            cgsl_pkg::S_LK_LAST: begin
                if (pos_reg >= mem_rpos) state_next = cgsl_pkg::S_OUT;
                else state_next = cgsl_pkg::S_LK_SCAN;
            end
            cgsl_pkg::S_LK_SCAN: begin
                if (mem_rpos > pos_reg || idx_reg == count_reg - CW'(1))
                    state_next = cgsl_pkg::S_LK_PAIR;
            end
            cgsl_pkg::S_LK_PAIR: state_next = cgsl_pkg::S_LK_DIV;
            // no division runs when the query sits on the lower stop
            cgsl_pkg::S_LK_DIV: begin
                if (!div_run_reg || div_rsp.done) state_next = cgsl_pkg::S_LK_MUL;
            end
            cgsl_pkg::S_LK_MUL: if (ch_reg == 2'd3) state_next = cgsl_pkg::S_OUT;
            cgsl_pkg::S_OUT: state_next = cgsl_pkg::S_IDLE;
            default: state_next = cgsl_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next = count_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        col_next = col_reg;
        p1_next = p1_reg;
        c1_next = c1_reg;
        p2_next = p2_reg;
        c2_next = c2_reg;
        amt_next = amt_reg;
        ch_next = ch_reg;
        ostat_next = ostat_reg;
        ocol_next = ocol_reg;
        ovalid_next = ovalid_reg && !out_ready;
        mem_we = 1'b0;
        mem_waddr = idx_reg[IW-1:0];
        mem_wpos = mem_rpos;
        mem_wcol = mem_rcol;
        mem_raddr = idx_reg[IW-1:0];
        div_req.start = 1'b0;
        div_req.num = pos_reg - p1_reg;
        div_req.den = p2_reg - p1_reg;
        case (state_reg)
            cgsl_pkg::S_IDLE: begin
                pos_next = (in_opcode == cgsl_pkg::OP_LOOKUP) ? folded : in_pos[PW-1:0];
                col_next = in_col;
                ch_next = '0;
                amt_next = '0;
                if (accept) begin
                    ostat_next = cgsl_pkg::ST_DONE;
                    ocol_next = '0;
                    case (in_opcode)
                        cgsl_pkg::OP_CLEAR: count_next = '0;
                        cgsl_pkg::OP_ADD: begin
                            if (pos_neg || in_pos > cgsl_pkg::PosW'(PosOne))
                                ostat_next = cgsl_pkg::ST_RANGE;
                            else if (count_reg >= CW'(cgsl_pkg::MaxStops))
                                ostat_next = cgsl_pkg::ST_FULL;
                            idx_next = count_reg;
                            mem_raddr = IW'(count_reg - CW'(1));
                        end
                        cgsl_pkg::OP_LOOKUP: mem_raddr = '0;
                        default: ;
                    endcase
                end
            end
            // walk down from the top, shifting larger stops up one slot
            cgsl_pkg::S_ADD_RD: begin
                if (pos_reg < mem_rpos) begin
                    mem_we = 1'b1;
                    mem_waddr = idx_reg[IW-1:0];
                    idx_next = idx_reg - CW'(1);
                    mem_raddr = IW'(idx_reg - CW'(2));
                end
            end
            cgsl_pkg::S_ADD_WR: begin
                mem_we = 1'b1;
                mem_wpos = pos_reg;
                mem_wcol = col_reg;
                count_next = count_reg + CW'(1);
            end
            cgsl_pkg::S_LK_FIRST: begin
                ocol_next = mem_rcol;
                mem_raddr = IW'(count_reg - CW'(1));
            end
            cgsl_pkg::S_LK_LAST: begin
                if (pos_reg >= mem_rpos) ocol_next = mem_rcol;
                idx_next = CW'(1);
                mem_raddr = IW'(1);
            end
            // find first stop above the query, capped at the last
            cgsl_pkg::S_LK_SCAN: begin
                p2_next = mem_rpos;
                c2_next = mem_rcol;
                mem_raddr = IW'(idx_reg - CW'(1));
                if (!(mem_rpos > pos_reg || idx_reg == count_reg - CW'(1))) begin
                    idx_next = idx_reg + CW'(1);
                    mem_raddr = IW'(idx_reg + CW'(1));
                end
            end
            cgsl_pkg::S_LK_PAIR: begin
                p1_next = mem_rpos;
                c1_next = mem_rcol;
            end
            cgsl_pkg::S_LK_MUL: begin
                ocol_next[16*ch_reg +: 16] = blend_sum[31:16];
                ch_next = ch_reg + 2'd1;
            end
            cgsl_pkg::S_OUT: begin
                ovalid_next = 1'b1;
                if (count_reg == '0 && ostat_reg == cgsl_pkg::ST_DONE
                    && ocol_reg == '0 && ch_reg == 2'd0 && lookup_empty_reg) begin
                    ocol_next = {16'hFFFF, gray_prod[31:16], gray_prod[31:16],
                                 gray_prod[31:16]};
                end
            end
            default: ;
        endcase
        if (state_reg == cgsl_pkg::S_LK_PAIR) begin
            div_req.start = (p2_next > mem_rpos) && (pos_reg > mem_rpos);
            div_req.num = pos_reg - mem_rpos;
            div_req.den = p2_reg - mem_rpos;
        end
        if (state_reg == cgsl_pkg::S_LK_DIV && div_rsp.done) amt_next = div_rsp.quo;
    end

    // empty-table lookup marker and divider run flag
    always_comb begin
        lookup_empty_next = lookup_empty_reg;
        div_run_next = div_run_reg;
        if (accept) lookup_empty_next = (in_opcode == cgsl_pkg::OP_LOOKUP) && count_reg == '0;
        if (state_reg == cgsl_pkg::S_LK_PAIR) div_run_next = div_req.start;
        if (div_rsp.done) div_run_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cgsl_pkg::S_IDLE;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
            lookup_empty_reg <= 1'b0;
            div_run_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovalid_reg <= ovalid_next;
            lookup_empty_reg <= lookup_empty_next;
            div_run_reg <= div_run_next;
        end
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        col_reg <= col_next;
        p1_reg <= p1_next;
        c1_reg <= c1_next;
        p2_reg <= p2_next;
        c2_reg <= c2_next;
        amt_reg <= amt_next;
        ch_reg <= ch_next;
        ostat_reg <= ostat_next;
        ocol_reg <= ocol_next;
    end

    assign out_valid = ovalid_reg;
    assign out_status = ostat_reg;
    assign out_col = ocol_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(cgsl_pkg::MaxStops)) else $error("stop count overflow");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> state_reg == cgsl_pkg::S_IDLE) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && !out_ready |=> ovalid_reg && $stable(ocol_reg))
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== hw/rtl/color_gradient_stop_lookup_core.sv =====
// top level: stream ports, register port, stop memory, sequencer and divider
// Gradient stop lookup. One item in, one result out, one item at a time. Clear,
// unused opcode, rejected adds and lookups on an empty table go straight to the
// result register. An accepted add shifts every stored stop above the new position
// up one slot through the stop memory's single write port, ends the shift with a
// compare when a stop at or below the new position remains, and then writes the new
// stop. A lookup at or before the first stop, or at or past the last stop, takes
// that stop's color. An interpolated lookup searches for the first stop above the
// position (one memory read a cycle), runs the serial fraction divider (skipped when
// the position sits on the lower stop) and then the per-channel blend multiplier.
`default_nettype none
module color_gradient_stop_lookup_core (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    output logic s_tready,
    // opcode[1:0], position_in[25:2], red_in[41:26], green_in[57:42],
    // blue_in[73:58], alpha_in[89:74], zero pad to 96
    input wire logic [95:0] s_tdata,
    output logic m_tvalid,
    input wire logic m_tready,
    // status[1:0], red_out[17:2], green_out[33:18], blue_out[49:34],
    // alpha_out[65:50], zero pad to 72
    output logic [71:0] m_tdata,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [1:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    logic [1:0] extend_reg;
    logic mem_we;
    logic [cgsl_pkg::IdxW-1:0] mem_waddr, mem_raddr;
    logic [cgsl_pkg::SPosW-1:0] mem_wpos, mem_rpos;
    logic [cgsl_pkg::ColW-1:0] mem_wcol, mem_rcol, out_col;
    logic [1:0] out_status;
    cgsl_pkg::div_req_t div_req;
    cgsl_pkg::div_rsp_t div_rsp;

    // register port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) extend_reg <= '0;
        else if (psel && penable && pwrite && {2'b00, paddr} == {cgsl_pkg::REG_EXTEND, 2'b00})
            extend_reg <= pwdata[1:0];
    end
    assign prdata = {30'd0, extend_reg};

    cgsl_stop_mem u_mem (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wpos(mem_wpos),
        .wcol(mem_wcol), .raddr(mem_raddr), .rpos(mem_rpos), .rcol(mem_rcol)
    );

    cgsl_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    cgsl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .extend_mode(extend_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_opcode(s_tdata[1:0]),
        .in_pos(s_tdata[25:2]), .in_col(s_tdata[89:26]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_status(out_status),
        .out_col(out_col), .mem_we(mem_we), .mem_waddr(mem_waddr),
        .mem_wpos(mem_wpos), .mem_wcol(mem_wcol), .mem_raddr(mem_raddr),
        .mem_rpos(mem_rpos), .mem_rcol(mem_rcol), .div_req(div_req), .div_rsp(div_rsp)
    );

    assign m_tdata = {6'd0, out_col, out_status};
endmodule
`default_nettype wire

// ===== tb/sv/color_gradient_stop_lookup_checker.sv =====
// checker for the gradient stop lookup block: predicts every result and compares
`default_nettype none
module color_gradient_stop_lookup_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [95:0] s_tdata,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [1:0] paddr,
    input wire logic [31:0] pwdata,
    input wire logic pready,
    output int fail_count,
    output int pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cgsl_pkg::status_t status;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } color_result_t;

    localparam logic signed [23:0] PosOne = 24'sh010000;

    // shadow copy of the stop table and the extend mode
    logic [cgsl_pkg::SPosW-1:0] stop_pos[cgsl_pkg::MaxStops];
    logic [cgsl_pkg::ColW-1:0] stop_col[cgsl_pkg::MaxStops];
    int stop_cnt;
    logic [1:0] ext_mode;
    color_result_t color_q[$];

    initial fail_count = 0;
    initial pending = 0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // fold a query position into 0..1 by the extend mode
    function automatic logic [cgsl_pkg::SPosW-1:0] fold_pos(input logic signed [23:0] q);
        case (ext_mode)
            cgsl_pkg::EXT_REPEAT: return {1'b0, q[15:0]};
            cgsl_pkg::EXT_REFLECT:
                return q[16] ? (17'h10000 - {1'b0, q[15:0]}) : {1'b0, q[15:0]};
            default: begin
                if (q < 0) return '0;
                if (q > PosOne) return 17'h10000;
                return q[16:0];
            end
        endcase
    endfunction

    function automatic logic [cgsl_pkg::ColW-1:0] mix_colors(
        input logic [cgsl_pkg::ColW-1:0] c1,
        input logic [cgsl_pkg::ColW-1:0] c2,
        input longint unsigned amt);
        logic [cgsl_pkg::ColW-1:0] r;
        longint unsigned a, b, v;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            a = c1[16*k +: 16];
            b = c2[16*k +: 16];
            v = (a * (65536 - amt) + b * amt) >> 16;
            r[16*k +: 16] = v[15:0];
        end
        return r;
    endfunction

    // apply one item to the shadow table and work out its result
    function automatic color_result_t predict_color(input logic [95:0] d);
        logic [1:0] op;
        logic signed [23:0] pos;
        logic [cgsl_pkg::ColW-1:0] col;
        logic [cgsl_pkg::SPosW-1:0] p;
        color_result_t r;
        int i, j, n;
        longint p1, p2, pl;
        longint unsigned amt, g;
        op = d[1:0];
        pos = d[25:2];
        col = d[89:26];
        r.status = cgsl_pkg::ST_DONE;
        r.red = '0;
        r.green = '0;
        r.blue = '0;
        r.alpha = '0;
        n = stop_cnt;
        case (op)
            cgsl_pkg::OP_CLEAR: stop_cnt = 0;
            cgsl_pkg::OP_ADD: begin
                if (pos < 0 || pos > PosOne) begin
                    r.status = cgsl_pkg::ST_RANGE;
                end else if (n >= cgsl_pkg::MaxStops) begin
                    r.status = cgsl_pkg::ST_FULL;
                end else begin
                    // new stop goes after every stop of equal position
                    i = 0;
                    while (i < n && !(pos[16:0] < stop_pos[i])) i++;
                    for (j = n; j > i; j--) begin
                        stop_pos[j] = stop_pos[j-1];
                        stop_col[j] = stop_col[j-1];
                    end
                    stop_pos[i] = pos[16:0];
                    stop_col[i] = col;
                    stop_cnt = n + 1;
                end
            end
            cgsl_pkg::OP_LOOKUP: begin
                p = fold_pos(pos);
                pl = p;
                if (n == 0) begin
                    g = (longint'(65535) * pl) >> 16;
                    r.red = g[15:0];
                    r.green = g[15:0];
                    r.blue = g[15:0];
                    r.alpha = 16'hffff;
                    return r;
                end
                if (n == 1 || p <= stop_pos[0]) begin
                    col = stop_col[0];
                end else if (p >= stop_pos[n-1]) begin
                    col = stop_col[n-1];
                end else begin
                    i = 0;
                    while (i + 2 < n && !(stop_pos[i+1] > p)) i++;
                    p1 = stop_pos[i];
                    p2 = stop_pos[i+1];
                    amt = 0;
                    if (p2 > p1 && pl > p1) begin
                        amt = ((pl - p1) << 16) / (p2 - p1);
                        if (amt > 65535) amt = 65535;
                    end
                    col = mix_colors(stop_col[i], stop_col[i+1], amt);
                end
                r.red = col[15:0];
                r.green = col[31:16];
                r.blue = col[47:32];
                r.alpha = col[63:48];
            end
            default: ;
        endcase
        return r;
    endfunction

    // results are checked before the same edge's input item is predicted
    always @(posedge aclk) begin
        color_result_t exp_r;
        if (!aresetn) begin
            stop_cnt = 0;
            ext_mode = cgsl_pkg::EXT_PAD;
            color_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (color_q.size() == 0) begin
                    report("result with no item waiting");
                end else begin
                    exp_r = color_q.pop_front();
                    if (m_tdata[1:0] !== exp_r.status)
                        report($sformatf("status %0d want %0d", m_tdata[1:0], exp_r.status));
                    if (m_tdata[17:2] !== exp_r.red)
                        report($sformatf("red %h want %h", m_tdata[17:2], exp_r.red));
                    if (m_tdata[33:18] !== exp_r.green)
                        report($sformatf("green %h want %h", m_tdata[33:18], exp_r.green));
                    if (m_tdata[49:34] !== exp_r.blue)
                        report($sformatf("blue %h want %h", m_tdata[49:34], exp_r.blue));
                    if (m_tdata[65:50] !== exp_r.alpha)
                        report($sformatf("alpha %h want %h", m_tdata[65:50], exp_r.alpha));
                end
            end
            if (psel && penable && pwrite && pready
                && {2'b00, paddr} == {cgsl_pkg::REG_EXTEND, 2'b00})
                ext_mode = pwdata[1:0];
            if (s_tvalid && s_tready)
                color_q.insert(color_q.size(), predict_color(s_tdata));
        end
        pending = color_q.size();
    end
endmodule
`default_nettype wire

// ===== tb/sv/color_gradient_stop_lookup_core_test.sv =====
// testbench top for the gradient stop lookup block: stimulus and verdict
`default_nettype none
module color_gradient_stop_lookup_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    // opcode, position_in, red_in, green_in, blue_in, alpha_in from bit 0 up
    logic [95:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // status, red_out, green_out, blue_out, alpha_out from bit 0 up
    logic [71:0] m_tdata;
    logic psel, penable, pwrite, pready;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;
    int fails, pending, sent;
    bit quiet;
    bit long_hold;

    color_gradient_stop_lookup_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    color_gradient_stop_lookup_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fails), .pending(pending)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    // run limit
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: random ready gaps, plus one long hold-off on request
    initial begin
        int w;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready = 0;
                repeat (300) @(negedge aclk);
                long_hold = 0;
            end
            w = quiet ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                m_tready = 0;
                repeat (w) @(negedge aclk);
            end
            m_tready = 1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
        end
    end

    task automatic send_item(input cgsl_pkg::opcode_t op, input logic [23:0] pos,
                             input logic [63:0] col);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = {6'b0, col, pos, op};
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    // wait for every result, then let the block go idle
    task automatic settle();
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        settle();
        @(negedge aclk);
        psel = 1;
        pwrite = 1;
        paddr = 2'({cgsl_pkg::REG_EXTEND, 2'b00});
        pwdata = {30'b0, m};
        penable = 0;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0;
        penable = 0;
    endtask

    function automatic logic [63:0] rand_col();
        return {$urandom, $urandom};
    endfunction

    // in-range stop position, often repeated values to make equal stops
    function automatic logic [23:0] stop_pos_rand();
        case ($urandom_range(0, 5))
            0: return 24'h0;
            1: return 24'h010000;
            2: return 24'(32'h1000 * $urandom_range(0, 15));
            default: return 24'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [23:0] query_pos_rand();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return {8'($urandom_range(0, 255)), 16'h0};
            2: return 24'(int'($urandom_range(0, 6)) * 65536 - 131072
                          + int'($urandom_range(0, 65535)));
            default: return 24'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        int k;
        logic [23:0] pos;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        quiet = 0;
        long_hold = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: empty table, range errors, equal stops, full table, ends
        send_item(cgsl_pkg::OP_LOOKUP, 24'h0, '0);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h010000, '0);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h800000, '0);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h7fffff, '0);
        send_item(cgsl_pkg::OP_ADD, 24'hffffff, '1);
        send_item(cgsl_pkg::OP_ADD, 24'h010001, '1);
        send_item(cgsl_pkg::OP_ADD, 24'h008000, '1);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h004000, '0);
        send_item(cgsl_pkg::OP_ADD, 24'h008000, '0);
        send_item(cgsl_pkg::OP_ADD, 24'h0, 64'h1234_5678_9abc_def0);
        send_item(cgsl_pkg::OP_ADD, 24'h010000, '1);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h008000, '0);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h00c000, '0);
        send_item(cgsl_pkg::OP_NONE, 24'hffffff, '1);
        for (k = 0; k < 13; k++) send_item(cgsl_pkg::OP_ADD, 24'(256 * k), rand_col());
        send_item(cgsl_pkg::OP_ADD, 24'h000100, '1);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h000180, '0);
        set_mode(cgsl_pkg::EXT_REFLECT);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h010000, '0);
        send_item(cgsl_pkg::OP_LOOKUP, 24'h030000, '0);
        send_item(cgsl_pkg::OP_CLEAR, 24'h0, '0);
        send_item(cgsl_pkg::OP_LOOKUP, 24'hfe8000, '0);

        // random: well-formed gradient sessions with noise, one phase per mode
        for (int m = 0; m < 4; m++) begin
            set_mode(2'(m));
            while (sent < 30 + (m + 1) * 360) begin
                quiet = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 9) == 0) long_hold = 1;
                if ($urandom_range(0, 9) < 7) begin
                    send_item(cgsl_pkg::OP_CLEAR, 24'($urandom), rand_col());
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18)
                                                    : $urandom_range(0, 6);
                    repeat (k) begin
                        pos = ($urandom_range(0, 15) == 0) ? 24'($urandom) : stop_pos_rand();
                        send_item(cgsl_pkg::OP_ADD, pos, rand_col());
                    end
                    repeat ($urandom_range(1, 8))
                        send_item(cgsl_pkg::OP_LOOKUP, query_pos_rand(), rand_col());
                end else begin
                    send_item(cgsl_pkg::opcode_t'($urandom_range(0, 3)), 24'($urandom),
                              rand_col());
                end
            end
        end

        quiet = 0;
        settle();
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
